/* src/pkfwrl_pkg.sv */
package pkfwrl_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int KEY_BITS_DEF      = 32;

  localparam int CFG_W   = 16;
  localparam int COUNT_W = 17;
  localparam int TIME_W  = 32;

  localparam logic [CFG_W-1:0] REQ_LIMIT_RST = 16'd100;
  localparam logic [CFG_W-1:0] WIN_LEN_RST   = 16'd60;

  // register indexes on the config port
  localparam logic REG_REQ_LIMIT = 1'b0;
  localparam logic REG_WIN_LEN   = 1'b1;

  typedef logic [1:0] status_t;
  localparam status_t ST_ALLOWED    = 2'd0;
  localparam status_t ST_LIMITED    = 2'd1;
  localparam status_t ST_TABLE_FULL = 2'd2;

endpackage

/* src/per_key_fixed_window_rate_limiter_top.sv */
// Channel   Direction  Handshake              Word
// in        sink       in_valid / in_stall    client_key, now_seconds
// out       source     out_valid / out_stall  status, remaining, seconds_to_reset
// cfg       sink       cfg_we                 cfg_index, cfg_data
//
// The table memory has one read port; every claimed entry is read once per request.
// Entries are claimed in order, so a fill count marks the live ones; reset clears it
// at once and there is no clearing pass.
// A finished result waits in the output register; the next request is taken meanwhile
// and its result waits in the decide step while out_stall holds the output.
module per_key_fixed_window_rate_limiter_top #(
  parameter int TABLE_ENTRIES = pkfwrl_pkg::TABLE_ENTRIES_DEF,
  parameter int KEY_BITS      = pkfwrl_pkg::KEY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [pkfwrl_pkg::CFG_W-1:0]    cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [31:0]                     client_key,
  input  logic [31:0]                     now_seconds,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pkfwrl_pkg::status_t             status,
  output logic [15:0]                     remaining,
  output logic [15:0]                     seconds_to_reset
);

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int FILL_W  = IDX_W + 1;
  localparam int CNT_W   = pkfwrl_pkg::COUNT_W;
  localparam int T_W     = pkfwrl_pkg::TIME_W;
  localparam int ENTRY_W = KEY_BITS + CNT_W + T_W;
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TABLE_ENTRIES);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0]                  state;
  logic [pkfwrl_pkg::CFG_W-1:0] req_limit;
  logic [pkfwrl_pkg::CFG_W-1:0] win_len;
  logic [FILL_W-1:0]           fill;
  logic [FILL_W-1:0]           rd_addr;
  logic                        chk_v;
  logic [IDX_W-1:0]            chk_idx;
  logic [KEY_BITS-1:0]         key_r;
  logic [T_W-1:0]              now_r;

  logic                        found;
  logic [IDX_W-1:0]            hit_idx;
  logic [CNT_W-1:0]            hit_cnt;
  logic [T_W-1:0]              hit_start;
  logic                        hit_exp;
  logic [15:0]                 hit_el;
  logic                        have_old;
  logic [IDX_W-1:0]            old_idx;

  logic [ENTRY_W-1:0]          mem [TABLE_ENTRIES];
  logic [ENTRY_W-1:0]          mem_q;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  logic [ENTRY_W-1:0]          mem_wdata;

  logic [KEY_BITS-1:0]         q_key;
  logic [CNT_W-1:0]            q_cnt;
  logic [T_W-1:0]              q_start;
  logic [T_W-1:0]              q_el;
  logic                        q_exp;

  logic                        in_take;
  logic                        out_load;
  logic [CNT_W-1:0]            lim1;
  logic [CNT_W-1:0]            cnt_inc;
  logic [CNT_W-1:0]            new_cnt;
  logic [15:0]                 el16;
  logic                        have_free;
  pkfwrl_pkg::status_t         status_next;
  logic [15:0]                 remaining_next;
  logic [15:0]                 to_reset_next;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_load = (state == S_DECIDE) && (!out_valid || !out_stall);

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[rd_addr[IDX_W-1:0]];
  end

  assign q_key   = mem_q[ENTRY_W-1 -: KEY_BITS];
  assign q_cnt   = mem_q[T_W +: CNT_W];
  assign q_start = mem_q[T_W-1:0];
  assign q_el    = now_r - q_start;
  assign q_exp   = (q_el >= {{(T_W-pkfwrl_pkg::CFG_W){1'b0}}, win_len});

  // decide: new count, result word and write-back
  always_comb begin
    lim1      = {1'b0, req_limit} + CNT_W'(1);
    cnt_inc   = hit_cnt + CNT_W'(1);
    have_free = (fill < FILL_MAX);
    if (hit_exp) begin
      new_cnt = CNT_W'(1);
      el16    = '0;
    end else begin
      new_cnt = (cnt_inc > lim1) ? lim1 : cnt_inc;
      el16    = hit_el;
    end
    status_next    = pkfwrl_pkg::ST_ALLOWED;
    remaining_next = '0;
    to_reset_next  = '0;
    mem_we         = 1'b0;
    mem_waddr      = hit_idx;
    mem_wdata      = {key_r, CNT_W'(1), now_r};
    if (found) begin
      to_reset_next = win_len - el16;
      if (new_cnt > {1'b0, req_limit}) begin
        status_next = pkfwrl_pkg::ST_LIMITED;
      end else begin
        remaining_next = req_limit - new_cnt[15:0];
      end
      mem_we    = out_load;
      mem_wdata = {key_r, new_cnt, hit_exp ? now_r : hit_start};
    end else if (have_free || have_old) begin
      to_reset_next  = win_len;
      remaining_next = (req_limit != '0) ? req_limit - 16'd1 : '0;
      mem_we         = out_load;
      mem_waddr      = have_free ? fill[IDX_W-1:0] : old_idx;
    end else begin
      status_next = pkfwrl_pkg::ST_TABLE_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      req_limit      <= pkfwrl_pkg::REQ_LIMIT_RST;
      win_len        <= pkfwrl_pkg::WIN_LEN_RST;
      fill           <= '0;
      rd_addr        <= '0;
      chk_v          <= 1'b0;
      found          <= 1'b0;
      have_old       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pkfwrl_pkg::REG_REQ_LIMIT: req_limit <= cfg_data;
          pkfwrl_pkg::REG_WIN_LEN:   win_len   <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            rd_addr  <= '0;
            chk_v    <= 1'b0;
            found    <= 1'b0;
            have_old <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue one read a cycle, check the word that came back
          if (rd_addr < fill) begin
            chk_v   <= 1'b1;
            chk_idx <= rd_addr[IDX_W-1:0];
            rd_addr <= rd_addr + FILL_W'(1);
          end else begin
            chk_v <= 1'b0;
            if (!chk_v) begin
              state <= S_DECIDE;
            end
          end
          if (chk_v) begin
            if (!found && (q_key == key_r)) begin
              found <= 1'b1;
            end
            if (!have_old && q_exp) begin
              have_old <= 1'b1;
            end
          end
        end
        S_DECIDE: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (!found && (fill < FILL_MAX)) begin
              fill <= fill + FILL_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      key_r <= KEY_BITS'(client_key);
      now_r <= now_seconds;
    end
    if ((state == S_SCAN) && chk_v) begin
      if (!found && (q_key == key_r)) begin
        hit_idx   <= chk_idx;
        hit_cnt   <= q_cnt;
        hit_start <= q_start;
        hit_exp   <= q_exp;
        hit_el    <= q_el[15:0];
      end
      if (!have_old && q_exp) begin
        old_idx <= chk_idx;
      end
    end
    if (out_load) begin
      status           <= status_next;
      remaining        <= remaining_next;
      seconds_to_reset <= to_reset_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_MAX)
    else $error("fill count past table size");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (fill != $past(fill)) |-> (fill == $past(fill) + FILL_W'(1))
      && $past(out_load) && !$past(found))
    else $error("fill count moved outside a new-key claim");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    out_load && (status_next == pkfwrl_pkg::ST_TABLE_FULL) |->
      (fill == FILL_MAX) && !have_old && !found)
    else $error("table full reported with room left");

  a_check_in_scan: assert property (@(posedge clk) disable iff (rst)
    chk_v |-> (state == S_SCAN))
    else $error("memory word checked outside the scan");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= pkfwrl_pkg::ST_TABLE_FULL))
    else $error("undefined status code on output");
`endif

endmodule

/* sim/per_key_fixed_window_rate_limiter_top_tb.sv */
`timescale 1ns / 1ps

module per_key_fixed_window_rate_limiter_top_tb;

  localparam int TABLE_SIZE = pkfwrl_pkg::TABLE_ENTRIES_DEF;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] now;
  } request_t;

  typedef struct packed {
    pkfwrl_pkg::status_t st;
    logic [15:0]         rem;
    logic [15:0]         ttr;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = pkfwrl_pkg::REG_REQ_LIMIT;
  logic [pkfwrl_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] client_key = '0;
  logic [31:0] now_seconds = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pkfwrl_pkg::status_t status;
  logic [15:0] remaining;
  logic [15:0] seconds_to_reset;

  per_key_fixed_window_rate_limiter_top DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .client_key(client_key),
    .now_seconds(now_seconds),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .remaining(remaining),
    .seconds_to_reset(seconds_to_reset)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the key table and the two registers
  bit          tab_used [TABLE_SIZE];
  logic [31:0] tab_key [TABLE_SIZE];
  logic [16:0] tab_cnt [TABLE_SIZE];
  logic [31:0] tab_start [TABLE_SIZE];
  logic [15:0] req_limit = pkfwrl_pkg::REQ_LIMIT_RST;
  logic [15:0] win_len = pkfwrl_pkg::WIN_LEN_RST;

  request_t pend_reqs[$];
  verdict_t due_verdicts[$];
  int fails = 0;
  int sent = 0;
  int quiet_cycles = 0;
  logic in_taken = 1'b0;
  logic no_gaps = 1'b0;

  function automatic verdict_t admit_request(input logic [31:0] key, input logic [31:0] now);
    verdict_t v;
    int hit;
    int free_slot;
    int old_slot;
    int s;
    logic [31:0] el;
    logic [31:0] c;
    logic [31:0] cap;
    logic [31:0] diff;
    hit = -1;
    free_slot = -1;
    old_slot = -1;
    v.st = pkfwrl_pkg::ST_ALLOWED;
    v.rem = '0;
    v.ttr = '0;
    cap = {16'd0, req_limit} + 32'd1;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (tab_used[i]) begin
        el = now - tab_start[i];
        if (hit < 0 && tab_key[i] == key) hit = i;
        if (old_slot < 0 && el >= {16'd0, win_len}) old_slot = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit >= 0) begin
      el = now - tab_start[hit];
      if (el >= {16'd0, win_len}) begin
        // window ran out: start over
        tab_cnt[hit] = 17'd1;
        tab_start[hit] = now;
        el = '0;
      end else begin
        c = {15'd0, tab_cnt[hit]} + 32'd1;
        if (c > cap) c = cap;
        tab_cnt[hit] = c[16:0];
      end
      diff = {16'd0, win_len} - el;
      v.ttr = diff[15:0];
      if ({15'd0, tab_cnt[hit]} > {16'd0, req_limit}) begin
        v.st = pkfwrl_pkg::ST_LIMITED;
      end else begin
        diff = {16'd0, req_limit} - {15'd0, tab_cnt[hit]};
        v.rem = diff[15:0];
      end
    end else if (free_slot >= 0 || old_slot >= 0) begin
      s = (free_slot >= 0) ? free_slot : old_slot;
      tab_used[s] = 1'b1;
      tab_key[s] = key;
      tab_cnt[s] = 17'd1;
      tab_start[s] = now;
      v.ttr = win_len;
      v.rem = (req_limit >= 16'd1) ? req_limit - 16'd1 : 16'd0;
    end else begin
      v.st = pkfwrl_pkg::ST_TABLE_FULL;
    end
    return v;
  endfunction

  // sender: hold the word until taken, then move on or go idle
  always @(negedge clk) begin : feed
    request_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold
    end else if (pend_reqs.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 15)) begin
      r = pend_reqs.pop_front();
      in_valid <= 1'b1;
      client_key <= r.key;
      now_seconds <= r.now;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_stall <= !rst && !no_gaps && ($urandom_range(0, 99) < 15);
  end

  // check results first, then predict the word taken at this edge
  always @(posedge clk) begin : watch
    verdict_t v;
    if (!rst && out_valid && !out_stall) begin
      if (due_verdicts.size() == 0) begin
        $error("unexpected result: status %0d remaining %0d seconds_to_reset %0d",
               status, remaining, seconds_to_reset);
        fails++;
      end else begin
        v = due_verdicts.pop_front();
        if (status !== v.st) begin
          $error("status mismatch: expected %0d, got %0d", v.st, status);
          fails++;
        end
        if (remaining !== v.rem) begin
          $error("remaining mismatch: expected %0d, got %0d", v.rem, remaining);
          fails++;
        end
        if (seconds_to_reset !== v.ttr) begin
          $error("seconds_to_reset mismatch: expected %0d, got %0d", v.ttr, seconds_to_reset);
          fails++;
        end
      end
    end
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) due_verdicts.push_back(admit_request(client_key, now_seconds));
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic push_req(input logic [31:0] key, input logic [31:0] now);
    request_t r;
    r.key = key;
    r.now = now;
    pend_reqs.push_back(r);
    sent++;
  endtask

  // caller waits here until every queued request is sent and every result is back
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pend_reqs.size() != 0 || in_valid || due_verdicts.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == pkfwrl_pkg::REG_REQ_LIMIT) req_limit = data;
    else win_len = data;
  endtask

  task automatic apply_config(input logic [15:0] lim_v, input logic [15:0] win_v);
    drain();
    write_reg(pkfwrl_pkg::REG_REQ_LIMIT, lim_v);
    write_reg(pkfwrl_pkg::REG_WIN_LEN, win_v);
  endtask

  task automatic random_phase(input int n, input int pool_n, input int step_hi);
    logic [31:0] pool[$];
    logic [31:0] t;
    int k;
    for (int i = 0; i < pool_n; i++) pool.push_back($urandom);
    t = $urandom;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 8) begin
        push_req($urandom, $urandom);
      end else if (k < 12) begin
        // jump the clock, often backwards
        t = $urandom;
        push_req(pool[$urandom_range(0, pool_n - 1)], t);
      end else begin
        t = t + $urandom_range(0, step_hi);
        push_req(pool[$urandom_range(0, pool_n - 1)], t);
      end
    end
  endtask

  initial begin : stimulus
    int p;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values, wrap of time and time going backwards
    push_req(32'h0000_0000, 32'h0000_0000);
    push_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(32'h0000_0000, 32'd5);
    push_req(32'hFFFF_FFFF, 32'd3);
    push_req(32'h0000_0000, 32'hFFFF_FFF0);

    // limit of one, longest window: saturate then expire
    apply_config(16'd1, 16'hFFFF);
    push_req(32'h0000_1234, 32'd100);
    push_req(32'h0000_1234, 32'd100);
    push_req(32'h0000_1234, 32'd100);
    push_req(32'h0000_1234, 32'd100 + 32'd65535);

    // largest limit, window of one
    apply_config(16'hFFFF, 16'd1);
    push_req(32'hA5A5_A5A5, 32'd7);
    push_req(32'hA5A5_A5A5, 32'd7);
    push_req(32'hA5A5_A5A5, 32'd8);

    apply_config(16'd2, 16'd10);
    repeat (4) push_req(32'h5A5A_5A5A, 32'd1000);
    push_req(32'h5A5A_5A5A, 32'd1010);

    // zero limit and zero window
    apply_config(16'd0, 16'd0);
    push_req(32'h5A5A_5A5A, 32'd2000);
    push_req(32'h0000_0077, 32'd2000);
    push_req(32'h0000_0077, 32'd2000);

    p = 0;
    while (sent < 1220) begin
      case (p % 4)
        0: begin
          apply_config(16'($urandom_range(1, 6)), 16'($urandom_range(5, 300)));
          no_gaps = (p == 4);
          random_phase(60, $urandom_range(3, 6), 1);
        end
        1: begin
          // many keys in one long window: table fills up
          apply_config(16'($urandom_range(1, 65535)), 16'hFFFF);
          no_gaps = 1'b0;
          random_phase(150, $urandom_range(70, 90), 2);
        end
        2: begin
          // short windows: new keys take expired entries
          apply_config(16'($urandom_range(1, 4)), 16'($urandom_range(1, 8)));
          no_gaps = 1'b0;
          random_phase(120, $urandom_range(70, 100), 2);
        end
        default: begin
          apply_config($urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(1, 65535)),
                       $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(1, 65535)));
          no_gaps = 1'b0;
          random_phase(60, $urandom_range(8, 40), $urandom_range(0, 100000));
        end
      endcase
      p++;
    end

    drain();
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
